// ----- sv/bqlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared widths, defaults and register indexes of the biquad low-pass filter.
// ----------------------------------------------------------------------------
package bqlp_pkg;

  // Fixed formats: delays are signed Q24.16 in 40 bits, coefficients 32 bits.
  localparam int DELAY_W    = 40;
  localparam int COEF_W     = 32;
  localparam int MUL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF  = 30;
  localparam int STATE_FRAC_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 2'd3;

endpackage

// ----- sv/biquad_lowpass_filter.sv -----
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Direct-form-II second-order low-pass biquad with Q24.16 delays, Q2.30
// coefficients, overflow substitution, output saturation and delay priming.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake               Payload
//  -------  ----------------------  -----------------------------------
//  input    in_valid / in_stall     func, sample
//  output   out_valid / out_stall   filtered, substituted
//  config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A filtered beat makes three passes through the shared multiply unit, plus
// sequencing, before the next beat is accepted.
// With the filter disabled a beat bypasses the multiply unit.
// A prime beat first runs the bit-serial divider, skipped when b0 is zero.
// Reset is synchronous; it clears the state, the configuration registers,
// out_valid and both delays. A finished result waits in the output register
// while the next beat is taken in; that beat only stalls at its end if the output is still held.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter
  import bqlp_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
  parameter int STATE_FRAC_BITS = STATE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] filtered,
  output logic                           substituted,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  localparam int SUM_W = DELAY_W + 2;
  localparam int SCL_W = SAMPLE_WIDTH + STATE_FRAC_BITS;
  localparam int MR_W  = SUM_W + COEF_W - COEF_FRAC_BITS + 1;
  localparam int D0_W  = ((SCL_W > MR_W) ? SCL_W : MR_W) + 2;
  localparam int SATW  = ((SCL_W > DELAY_W) ? SCL_W : DELAY_W) + 1;
  localparam int YHW   = MR_W - SAMPLE_WIDTH + 1;

  localparam logic signed [SATW-1:0] DMAX =
    {{(SATW-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
  localparam logic signed [SATW-1:0] DMIN =
    {{(SATW-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};
  localparam logic signed [MR_W-1:0] YMAX =
    {{YHW{1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [MR_W-1:0] YMIN =
    {{YHW{1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PRIME  = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_BYPASS = 4'd3;
  localparam logic [3:0] S_MA1    = 4'd4;
  localparam logic [3:0] S_WA1    = 4'd5;
  localparam logic [3:0] S_WA2    = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_MB     = 4'd9;
  localparam logic [3:0] S_WB     = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  logic                           enable;
  logic signed [COEF_W-1:0]       coef_b0;
  logic signed [COEF_W-1:0]       coef_a1;
  logic signed [COEF_W-1:0]       coef_a2;
  logic signed [DELAY_W-1:0]      delay_one;
  logic signed [DELAY_W-1:0]      delay_two;

  logic signed [SAMPLE_WIDTH-1:0] smp_q;
  logic signed [D0_W-1:0]         tmp;
  logic signed [D0_W-1:0]         d0;
  logic signed [DELAY_W-1:0]      d0_fix;
  logic signed [SUM_W-1:0]        sum_q;
  logic signed [SAMPLE_WIDTH-1:0] y_val;
  logic                           sub_val;

  logic signed [SCL_W-1:0]        scaled;
  logic signed [SATW-1:0]         scaled_ext;
  logic signed [DELAY_W-1:0]      scaled_sat;
  logic [D0_W-DELAY_W:0]          d0_hi;
  logic                           d0_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  logic                           mul_start;
  logic                           mul_long;
  logic signed [SUM_W-1:0]        mul_x;
  logic signed [COEF_W-1:0]       mul_c;
  logic                           mul_done;
  logic signed [MR_W-1:0]         mul_res;

  logic                           div_start;
  logic                           div_done;
  logic signed [DELAY_W-1:0]      div_q;

  logic                           in_take;
  logic                           out_load;

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && !(out_valid && out_stall);

  // Sample in the delay format, clipped to the 40-bit delay range.
  assign scaled     = $signed({smp_q, {STATE_FRAC_BITS{1'b0}}});
  assign scaled_ext = SATW'(scaled);

  always_comb begin
    if (scaled_ext > DMAX) begin
      scaled_sat = DMAX[DELAY_W-1:0];
    end else if (scaled_ext < DMIN) begin
      scaled_sat = DMIN[DELAY_W-1:0];
    end else begin
      scaled_sat = scaled_ext[DELAY_W-1:0];
    end
  end

  assign d0_hi  = d0[D0_W-1:DELAY_W-1];
  assign d0_ovf = !((&d0_hi) || !(|d0_hi));

  always_comb begin
    if (mul_res > YMAX) begin
      y_sat = YMAX[SAMPLE_WIDTH-1:0];
    end else if (mul_res < YMIN) begin
      y_sat = YMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = mul_res[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_long  = 1'b0;
    mul_x     = SUM_W'(delay_one);
    mul_c     = coef_a1;
    case (state)
      S_MA1: mul_start = 1'b1;
      S_WA1: begin
        mul_start = mul_done;
        mul_x     = SUM_W'(delay_two);
        mul_c     = coef_a2;
      end
      S_MB: begin
        mul_start = 1'b1;
        mul_long  = 1'b1;
        mul_x     = sum_q;
        mul_c     = coef_b0;
      end
      default: ;
    endcase
  end

  assign div_start = (state == S_PRIME) && (coef_b0 != '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = func ? S_PRIME : (enable ? S_MA1 : S_BYPASS);
        end
      end
      S_PRIME: begin
        if (coef_b0 != '0) begin
          state_next = S_DIV;
        end else begin
          state_next = enable ? S_MA1 : S_BYPASS;
        end
      end
      S_DIV:    if (div_done) state_next = enable ? S_MA1 : S_BYPASS;
      S_BYPASS: state_next = S_OUT;
      S_MA1:    state_next = S_WA1;
      S_WA1:    if (mul_done) state_next = S_WA2;
      S_WA2:    if (mul_done) state_next = S_CHK;
      S_CHK:    state_next = S_SUM;
      S_SUM:    state_next = S_MB;
      S_MB:     state_next = S_WB;
      S_WB:     if (mul_done) state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      coef_b0 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:  enable  <= cfg_data[0];
        REG_COEF_B0: coef_b0 <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_A1: coef_a1 <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_A2: coef_a2 <= $signed(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      case (state)
        S_PRIME: begin
          // With b0 zero the delays take the scaled, clipped sample.
          if (coef_b0 == '0) begin
            delay_one <= scaled_sat;
            delay_two <= scaled_sat;
          end
        end
        S_DIV: begin
          if (div_done) begin
            delay_one <= div_q;
            delay_two <= div_q;
          end
        end
        S_WB: begin
          if (mul_done) begin
            delay_two <= delay_one;
            delay_one <= d0_fix;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_q <= sample;
    end
    case (state)
      S_BYPASS: begin
        y_val   <= smp_q;
        sub_val <= 1'b0;
      end
      S_WA1: if (mul_done) tmp <= D0_W'(scaled) - D0_W'(mul_res);
      S_WA2: if (mul_done) d0 <= tmp - D0_W'(mul_res);
      S_CHK: begin
        // A d0 outside the delay range is replaced by the clipped sample.
        d0_fix  <= d0_ovf ? scaled_sat : d0[DELAY_W-1:0];
        sub_val <= d0_ovf;
      end
      S_SUM: sum_q <= SUM_W'(d0_fix) + (SUM_W'(delay_one) <<< 1) + SUM_W'(delay_two);
      S_WB:  if (mul_done) y_val <= y_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered    <= y_val;
      substituted <= sub_val;
    end
  end

  bqlp_mulrnd #(
    .X_W         (SUM_W),
    .SHORT_SHIFT (COEF_FRAC_BITS),
    .LONG_SHIFT  (COEF_FRAC_BITS + STATE_FRAC_BITS),
    .RES_W       (MR_W)
  ) u_mul (
    .clk        (clk),
    .rst        (rst),
    .start      (mul_start),
    .long_shift (mul_long),
    .x          (mul_x),
    .c          (mul_c),
    .done       (mul_done),
    .res        (mul_res)
  );

  bqlp_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SHIFT        (STATE_FRAC_BITS + COEF_FRAC_BITS - 2)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_in (smp_q),
    .den_in (coef_b0),
    .done   (div_done),
    .q      (div_q)
  );

  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_WA1 || state == S_WA2 || state == S_WB))
    else $error("multiply result arrived outside a wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result arrived outside the prime wait");

  a_bypass_value: assert property (@(posedge clk) disable iff (rst)
    (state == S_BYPASS) |=> (y_val == $past(smp_q) && !sub_val))
    else $error("disabled beat did not pass the sample through");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && filtered == $past(y_val) && substituted == $past(sub_val)))
    else $error("output register did not take the finished result");

endmodule

// ----- sv/bqlp_mulrnd.sv -----
// ----------------------------------------------------------------------------
// bqlp_mulrnd
// Shared multiply unit: signed x times signed c, shifted right by one of two
// amounts, rounded to nearest with ties away from zero. The low and high parts
// of |x| are each multiplied by |c| in turn, and done rises with the result.
// ----------------------------------------------------------------------------
module bqlp_mulrnd
  import bqlp_pkg::*;
#(
  parameter int X_W         = DELAY_W + 2,
  parameter int SHORT_SHIFT = COEF_FRAC_BITS_DEF,
  parameter int LONG_SHIFT  = COEF_FRAC_BITS_DEF + STATE_FRAC_BITS_DEF,
  parameter int RES_W       = X_W + COEF_W - COEF_FRAC_BITS_DEF + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    long_shift,
  input  logic signed [X_W-1:0]   x,
  input  logic signed [COEF_W-1:0] c,
  output logic                    done,
  output logic signed [RES_W-1:0] res
);

  localparam int HI_W   = X_W - MUL_W;
  localparam int PROD_W = MUL_W + COEF_W;
  localparam int PW     = X_W + COEF_W;
  localparam int MAG_W  = RES_W - 1;

  localparam logic [PW-1:0] ONE_P  = {{(PW-1){1'b0}}, 1'b1};
  localparam logic [PW-1:0] HALF_S = ONE_P << (SHORT_SHIFT - 1);
  localparam logic [PW-1:0] HALF_L = ONE_P << (LONG_SHIFT - 1);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_LO   = 3'd1;
  localparam logic [2:0] P_HI   = 3'd2;
  localparam logic [2:0] P_ADD  = 3'd3;
  localparam logic [2:0] P_SIGN = 3'd4;

  logic [2:0]        phase;
  logic [X_W-1:0]    xm;
  logic [COEF_W-1:0] cm;
  logic              neg;
  logic              long_sel;
  logic [PROD_W-1:0] prod;
  logic [PW-1:0]     acc;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] p_lo;
  logic [PROD_W-1:0] p_hi;
  logic [PW-1:0]     total;

  assign p_lo  = xm[MUL_W-1:0] * cm;
  assign p_hi  = {{(MUL_W-HI_W){1'b0}}, xm[X_W-1:MUL_W]} * cm;
  assign total = acc + (PW'(prod) << MUL_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == P_SIGN);
      case (phase)
        P_IDLE: if (start) phase <= P_LO;
        P_LO:   phase <= P_HI;
        P_HI:   phase <= P_ADD;
        P_ADD:  phase <= P_SIGN;
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      P_IDLE: begin
        if (start) begin
          xm       <= x[X_W-1] ? $unsigned(-x) : $unsigned(x);
          cm       <= c[COEF_W-1] ? $unsigned(-c) : $unsigned(c);
          neg      <= x[X_W-1] ^ c[COEF_W-1];
          long_sel <= long_shift;
        end
      end
      P_LO: prod <= p_lo;
      P_HI: begin
        acc  <= PW'(prod) + (long_sel ? HALF_L : HALF_S);
        prod <= p_hi;
      end
      P_ADD: mag <= long_sel ? MAG_W'(total >> LONG_SHIFT) : MAG_W'(total >> SHORT_SHIFT);
      P_SIGN: res <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      default: ;
    endcase
  end

endmodule

// ----- sv/bqlp_div.sv -----
// ----------------------------------------------------------------------------
// bqlp_div
// Restoring divider for the prime value: (|sample| << SHIFT) / |b0|, one
// quotient bit per cycle, then rounding and saturation to the delay range.
// ----------------------------------------------------------------------------
module bqlp_div
  import bqlp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SHIFT        = STATE_FRAC_BITS_DEF + COEF_FRAC_BITS_DEF - 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] num_in,
  input  logic signed [COEF_W-1:0]       den_in,
  output logic                           done,
  output logic signed [DELAY_W-1:0]      q
);

  localparam int DW    = SAMPLE_WIDTH + SHIFT;
  localparam int CNT_W = $clog2(DW + 1);
  localparam int QR_W  = DELAY_W + 2;

  localparam logic [QR_W-1:0] LIM =
    {{(QR_W-DELAY_W){1'b0}}, 1'b1, {(DELAY_W-1){1'b0}}};
  localparam logic [QR_W-1:0] LIM_M1 = LIM - {{(QR_W-1){1'b0}}, 1'b1};
  localparam logic [DELAY_W-1:0] QMAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic [DELAY_W-1:0] QMIN = {1'b1, {(DELAY_W-1){1'b0}}};

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_RUN   = 2'd1;
  localparam logic [1:0] D_ROUND = 2'd2;
  localparam logic [1:0] D_SAT   = 2'd3;

  logic [1:0]              phase;
  logic [CNT_W-1:0]        cnt;
  logic [SAMPLE_WIDTH-1:0] num;
  logic [COEF_W-1:0]       den;
  logic                    neg;
  logic [COEF_W-1:0]       rem;
  logic [DELAY_W:0]        quo;
  logic                    big;
  logic [QR_W-1:0]         qr;
  logic [COEF_W:0]         rem_sh;
  logic                    fits;
  logic                    round_up;

  assign rem_sh   = {rem, num[SAMPLE_WIDTH-1]};
  assign fits     = rem_sh >= {1'b0, den};
  assign round_up = {rem, 1'b0} >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == D_SAT);
      case (phase)
        D_IDLE:  if (start) phase <= D_RUN;
        D_RUN:   if (cnt == CNT_W'(1)) phase <= D_ROUND;
        D_ROUND: phase <= D_SAT;
        default: phase <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      D_IDLE: begin
        if (start) begin
          num <= num_in[SAMPLE_WIDTH-1] ? $unsigned(-num_in) : $unsigned(num_in);
          den <= den_in[COEF_W-1] ? $unsigned(-den_in) : $unsigned(den_in);
          neg <= num_in[SAMPLE_WIDTH-1] ^ den_in[COEF_W-1];
          rem <= '0;
          quo <= '0;
          big <= 1'b0;
          cnt <= CNT_W'(DW);
        end
      end
      D_RUN: begin
        rem <= fits ? COEF_W'(rem_sh - {1'b0, den}) : rem_sh[COEF_W-1:0];
        num <= num << 1;
        // Quotient bits that fall off the top only matter as a saturation mark.
        quo <= {quo[DELAY_W-1:0], fits};
        big <= big | quo[DELAY_W];
        cnt <= cnt - CNT_W'(1);
      end
      D_ROUND: qr <= {1'b0, quo} + QR_W'(round_up);
      default: begin
        if (neg) begin
          q <= (big || qr > LIM) ? $signed(QMIN) : $signed(~qr[DELAY_W-1:0] + 1'b1);
        end else begin
          q <= (big || qr > LIM_M1) ? $signed(QMAX) : $signed(qr[DELAY_W-1:0]);
        end
      end
    endcase
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the biquad low-pass filter. The bench drives
// samples and prime commands, reprograms enable and coefficients between
// phases, and checks every output beat against an in-bench fixed-point filter.
// ----------------------------------------------------------------------------
module tb
  import bqlp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int CF          = COEF_FRAC_BITS_DEF;
  localparam int SF          = STATE_FRAC_BITS_DEF;
  localparam int PRIME_SHIFT = SF + CF - 2;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic signed [SW-1:0] filtered;
    logic                 substituted;
  } filt_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  func = 1'b0;
  logic signed [SW-1:0]  sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [SW-1:0]  filtered;
  logic                  substituted;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Filter state as the bench tracks it.
  logic         flt_enable = 1'b0;
  longint       flt_b0 = 0;
  longint       flt_a1 = 0;
  longint       flt_a2 = 0;
  longint       flt_delay1 = 0;
  longint       flt_delay2 = 0;

  filt_result_t pending_outputs[$];
  int           errors = 0;
  int           cycle_count = 0;
  bit           quiet = 1'b0;
  int unsigned  stall_left = 0;

  biquad_lowpass_filter u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .filtered    (filtered),
    .substituted (substituted),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point filter arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint saturate(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // x * c / 2^n, rounded to nearest with ties away from zero.
  function automatic longint round_product(input longint x, input longint c, input int n);
    logic [127:0] prod;
    logic [61:0]  mag_q;
    bit           neg;
    neg   = (x < 0) != (c < 0);
    prod  = 128'(magnitude(x)) * 128'(magnitude(c) & 64'h1_FFFF_FFFF);
    prod  = prod + (128'd1 << (n - 1));
    mag_q = 62'(prod >> n);
    return neg ? -longint'(mag_q) : longint'(mag_q);
  endfunction

  // Delay level that a prime command loads: sample / (4 * b0), or the scaled sample when b0 is zero.
  function automatic longint prime_level(input longint smp);
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned lim;
    bit              neg;
    lim = 64'd1 << (DELAY_W - 1);
    if (flt_b0 == 0) return saturate(smp * (64'sd1 <<< SF), DELAY_W);
    num = magnitude(smp) << PRIME_SHIFT;
    den = magnitude(flt_b0);
    quo = num / den;
    rem = num % den;
    if (2 * rem >= den) quo++;
    neg = (smp < 0) != (flt_b0 < 0);
    if (neg) return (quo > lim) ? -longint'(lim) : -longint'(quo);
    return (quo > lim - 1) ? longint'(lim - 1) : longint'(quo);
  endfunction

  function automatic filt_result_t lowpass_output(input logic f,
                                                  input logic signed [SW-1:0] s);
    longint       smp;
    longint       scaled;
    longint       lim;
    longint       d0;
    longint       y;
    longint       lvl;
    filt_result_t res;
    smp    = s;
    scaled = smp * (64'sd1 <<< SF);
    lim    = 64'sd1 <<< (DELAY_W - 1);
    res.substituted = 1'b0;
    if (f) begin
      lvl        = prime_level(smp);
      flt_delay1 = lvl;
      flt_delay2 = lvl;
    end
    if (!flt_enable) begin
      res.filtered = s;
      return res;
    end
    d0 = scaled - round_product(flt_delay1, flt_a1, CF)
                - round_product(flt_delay2, flt_a2, CF);
    // A delay value that leaves the 40-bit range is replaced by the clipped, scaled sample.
    if (d0 >= lim || d0 < -lim) begin
      d0 = saturate(scaled, DELAY_W);
      res.substituted = 1'b1;
    end
    y = round_product(d0 + 2 * flt_delay1 + flt_delay2, flt_b0, CF + SF);
    y = saturate(y, SW);
    flt_delay2   = flt_delay1;
    flt_delay1   = d0;
    res.filtered = y[SW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_extreme_coef();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Valid stays high after the beat so that back-to-back beats never drop it.
  task automatic send_sample(input logic f, input logic signed [SW-1:0] s);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      func     <= 1'($urandom_range(0, 1));
      sample   <= SW'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outputs.push_back(lowpass_output(f, s));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLE:  flt_enable = val[0];
      REG_COEF_B0: flt_b0     = $signed(val);
      REG_COEF_A1: flt_a1     = $signed(val);
      REG_COEF_A2: flt_a2     = $signed(val);
      default:     ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  // The block must be idle before it is reprogrammed.
  task automatic configure(input logic en, input logic [31:0] b0,
                           input logic [31:0] a1, input logic [31:0] a2);
    wait_idle();
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Straight out of reset the filter is disabled and b0 is zero, so a prime
  // loads the scaled sample and the output still passes through.
  task automatic test_reset_passthrough();
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b0, -16'sd32768);
    send_sample(1'b1, -16'sd1);
    send_sample(1'b0, 16'sd1);
  endtask

  task automatic test_lowpass_directed();
    configure(1'b1, 32'd72434000, -32'sd1227287000, 32'd443241000);
    send_sample(1'b1, 16'sd10000);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b0, -16'sd32768);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b0, 16'sd12345);
  endtask

  task automatic test_overflow_and_saturation();
    // A tiny b0 saturates the primed delays; a1 = a2 = -2.0 then pushes the
    // next delay value out of range.
    configure(1'b1, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
    send_sample(1'b1, 16'sd32767);
    send_sample(1'b0, 16'sd0);
    send_sample(1'b0, -16'sd20000);
    send_sample(1'b1, -16'sd32768);
    send_sample(1'b0, 16'sd100);
    // A gain near 2.0 drives the output into saturation both ways.
    configure(1'b1, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b0, 16'sd32767);
    send_sample(1'b0, -16'sd32768);
    send_sample(1'b0, -16'sd32768);
    configure(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(1'b1, 16'sd1);
    send_sample(1'b0, -16'sd1);
  endtask

  task automatic test_random_phases();
    logic               en;
    logic [31:0]        b0;
    logic [31:0]        a1;
    logic [31:0]        a2;
    logic signed [SW-1:0] level;
    logic               f;
    int                 v;
    int unsigned        r;
    level = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      en    = 1'b1;
      quiet = (ph == 0) || (ph == 9);
      case (ph)
        0, 9: begin
          b0 = 32'd72434000;  a1 = -32'sd1227287000; a2 = 32'd443241000;
          en = (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1));
        end
        1: begin
          b0 = 32'd314485000; a1 = 32'd0;            a2 = 32'd184220000;
        end
        2, 6: begin
          b0 = 32'd3888700;   a1 = -32'sd1957100000; a2 = 32'd898860000;
        end
        3, 8: begin
          b0 = $urandom; a1 = $urandom; a2 = $urandom;
          en = (ph == 3) ? 1'($urandom_range(0, 1)) : 1'b1;
        end
        5: begin
          b0 = $urandom; a1 = $urandom; a2 = $urandom;
          en = 1'b0;
        end
        default: begin
          b0 = pick_extreme_coef(); a1 = pick_extreme_coef(); a2 = pick_extreme_coef();
        end
      endcase
      configure(en, b0, a1, a2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // Mostly a wandering signal, as a sensor would deliver.
          v = int'(level) + int'($urandom_range(0, 4095)) - 2048;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          level = v[SW-1:0];
        end else if (r < 85) begin
          level = SW'($urandom);
        end else begin
          case ($urandom_range(0, 4))
            0:       level = 16'sd32767;
            1:       level = -16'sd32768;
            2:       level = 16'sd0;
            3:       level = 16'sd1;
            default: level = -16'sd1;
          endcase
        end
        f = ($urandom_range(0, 19) == 0);
        send_sample(f, level);
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls and result checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = pick_gap();
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    filt_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected output beat: filtered %0d substituted %0b",
                   filtered, substituted);
      end else begin
        want = pending_outputs.pop_front();
        if (filtered !== want.filtered || substituted !== want.substituted) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: filtered exp %0d got %0d, substituted exp %0b got %0b",
                     want.filtered, filtered, want.substituted, substituted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_passthrough();
    test_lowpass_directed();
    test_overflow_and_saturation();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
